// ===== sv/fse_pkg.sv =====
package fse_pkg;

    // Table sizes.
    localparam int NUM_SOURCES = 256;
    localparam int RING_EVENTS = 50;
    localparam int SRC_W       = $clog2(NUM_SOURCES);
    localparam int PTR_W       = $clog2(RING_EVENTS);
    localparam int RING_DEPTH  = NUM_SOURCES * RING_EVENTS;
    localparam int RING_AW     = $clog2(RING_DEPTH);

    // Field widths.
    localparam int IDX_W   = 8;
    localparam int TIME_W  = 32;
    localparam int WIN_W   = 8;
    localparam int ACT_W   = 2;
    localparam int LVL_W   = 2;
    localparam int COUNT_W = 32;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(3);

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REJECT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DROP   = 2'd2;

    // Escalation levels.
    localparam logic [LVL_W-1:0] LVL_CLEAR   = 2'd0;
    localparam logic [LVL_W-1:0] LVL_REJECTED = 2'd1;
    localparam logic [LVL_W-1:0] LVL_DROPPED  = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SRC,
        S_RING,
        S_CMP,
        S_OUT
    } t_state;

    // Per-source record held in the source memory.
    typedef struct packed {
        logic [PTR_W-1:0]   ptr;
        logic [LVL_W-1:0]   level;
        logic [COUNT_W-1:0] count;
    } t_src_state;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic in_ready;
        logic capture;
        logic src_stage;
        logic ring_op;
        logic compute;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_sts;

    // Reduce an input index modulo the table size by compare and subtract.
    function automatic logic [SRC_W-1:0] src_of(input logic [IDX_W-1:0] idx);
        int unsigned v;
        v = int'(idx);
        for (int k = IDX_W - 1; k >= 0; k--) begin
            if (v >= (NUM_SOURCES << k)) begin
                v = v - (NUM_SOURCES << k);
            end
        end
        return SRC_W'(v);
    endfunction

endpackage

// ===== sv/fse_if.sv =====
// Input channel: one packet event per beat.
interface fse_in_if;
    logic                         valid;
    logic                         ready;
    logic [fse_pkg::IDX_W-1:0]    source_index;
    logic [fse_pkg::TIME_W-1:0]   arrival_sec;

    modport source (output valid, output source_index, output arrival_sec, input ready);
    modport sink   (input valid, input source_index, input arrival_sec, output ready);
endinterface

// Output channel: one verdict per beat.
interface fse_out_if;
    logic                         valid;
    logic                         ready;
    logic [fse_pkg::IDX_W-1:0]    source_echo;
    logic [fse_pkg::ACT_W-1:0]    action;
    logic                         burst_seen;
    logic [fse_pkg::LVL_W-1:0]    level;
    logic [fse_pkg::COUNT_W-1:0]  event_count;

    modport source (output valid, output source_echo, output action, output burst_seen,
                    output level, output event_count, input ready);
    modport sink   (input valid, input source_echo, input action, input burst_seen,
                    input level, input event_count, output ready);
endinterface

// ===== sv/fse_ctrl.sv =====
module fse_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fse_pkg::t_sts i_sts,
    output fse_pkg::t_cmd o_cmd
);

    fse_pkg::t_state r_state;
    fse_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fse_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            fse_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = fse_pkg::S_SRC;
                end
            end
            fse_pkg::S_SRC: begin
                o_cmd.src_stage = 1'b1;
                n_state         = fse_pkg::S_RING;
            end
            fse_pkg::S_RING: begin
                o_cmd.ring_op = 1'b1;
                n_state       = fse_pkg::S_CMP;
            end
            fse_pkg::S_CMP: begin
                o_cmd.compute = 1'b1;
                n_state       = fse_pkg::S_OUT;
            end
            fse_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = fse_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fse_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/fse_dp.sv =====
module fse_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [fse_pkg::WIN_W-1:0]   i_cfg_wdata,
    input  fse_pkg::t_cmd               i_cmd,
    output fse_pkg::t_sts               o_sts,
    fse_in_if.sink                      i_in,
    fse_out_if.source                   o_out
);

    // Memories: per-source records and the arrival rings.
    fse_pkg::t_src_state           r_src_mem  [fse_pkg::NUM_SOURCES];
    logic [fse_pkg::TIME_W-1:0]    r_ring_mem [fse_pkg::RING_DEPTH];
    logic [fse_pkg::NUM_SOURCES-1:0] r_src_valid;

    logic [fse_pkg::WIN_W-1:0]     r_window;

    logic [fse_pkg::SRC_W-1:0]     r_src;
    logic [fse_pkg::IDX_W-1:0]     r_echo;
    logic [fse_pkg::TIME_W-1:0]    r_now;
    fse_pkg::t_src_state           r_st_q;
    logic                          r_st_vld_q;
    fse_pkg::t_src_state           r_prior;
    logic [fse_pkg::PTR_W-1:0]     r_next_ptr;
    logic [fse_pkg::RING_AW-1:0]   r_wr_addr;
    logic [fse_pkg::RING_AW-1:0]   r_rd_addr;
    logic [fse_pkg::TIME_W-1:0]    r_ring_q;

    logic [fse_pkg::ACT_W-1:0]     r_res_action;
    logic                          r_res_burst;
    logic [fse_pkg::LVL_W-1:0]     r_res_level;
    logic [fse_pkg::COUNT_W-1:0]   r_res_count;

    logic                          r_out_valid;
    logic [fse_pkg::IDX_W-1:0]     r_out_echo;
    logic [fse_pkg::ACT_W-1:0]     r_out_action;
    logic                          r_out_burst;
    logic [fse_pkg::LVL_W-1:0]     r_out_level;
    logic [fse_pkg::COUNT_W-1:0]   r_out_count;

    logic [fse_pkg::SRC_W-1:0]     in_src;
    fse_pkg::t_src_state           eff_state;
    logic [fse_pkg::PTR_W-1:0]     nxt_ptr;
    logic [fse_pkg::RING_AW-1:0]   ring_base;
    logic [fse_pkg::TIME_W-1:0]    oldest;
    logic signed [fse_pkg::TIME_W+1:0] diff;
    logic                          burst;
    logic [fse_pkg::COUNT_W-1:0]   new_count;
    logic [fse_pkg::LVL_W-1:0]     new_level;
    logic [fse_pkg::ACT_W-1:0]     new_action;

    // Handshake wiring.
    assign i_in.ready      = i_cmd.in_ready;
    assign o_sts.in_valid  = i_in.valid;
    assign o_sts.out_free  = !r_out_valid || o_out.ready;
    assign in_src          = fse_pkg::src_of(i_in.source_index);

    // Window register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= fse_pkg::WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    // Capture the event and read the source record.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_src      <= in_src;
            r_echo     <= i_in.source_index;
            r_now      <= i_in.arrival_sec;
            r_st_q     <= r_src_mem[in_src];
            r_st_vld_q <= r_src_valid[in_src];
        end
    end

    // Resolve the record and form the ring addresses.
    always_comb begin
        eff_state = r_st_vld_q ? r_st_q : '0;
        nxt_ptr   = (eff_state.ptr == fse_pkg::PTR_W'(fse_pkg::RING_EVENTS - 1))
                    ? '0 : eff_state.ptr + fse_pkg::PTR_W'(1);
        ring_base = fse_pkg::RING_AW'(r_src) * fse_pkg::RING_AW'(fse_pkg::RING_EVENTS);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.src_stage) begin
            r_prior    <= eff_state;
            r_next_ptr <= nxt_ptr;
            r_wr_addr  <= ring_base + fse_pkg::RING_AW'(eff_state.ptr);
            r_rd_addr  <= ring_base + fse_pkg::RING_AW'(nxt_ptr);
        end
    end

    // Ring access: write the new time, read the oldest slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ring_op) begin
            r_ring_mem[r_wr_addr] <= r_now;
            r_ring_q              <= r_ring_mem[r_rd_addr];
        end
    end

    // Window test and escalation. A slot not yet written holds time zero;
    // the ring fills in order, so that is the case while the source has
    // seen fewer than one ring's worth of events less one.
    always_comb begin
        oldest     = (r_prior.count < fse_pkg::COUNT_W'(fse_pkg::RING_EVENTS - 1))
                     ? '0 : r_ring_q;
        diff       = $signed({2'b00, r_now}) - $signed({2'b00, oldest});
        burst      = diff < $signed({{(fse_pkg::TIME_W + 2 - fse_pkg::WIN_W){1'b0}}, r_window});
        new_count  = (&r_prior.count) ? r_prior.count
                                      : r_prior.count + fse_pkg::COUNT_W'(1);
        new_level  = r_prior.level;
        new_action = fse_pkg::ACT_NONE;
        if (burst) begin
            priority if (r_prior.level == fse_pkg::LVL_CLEAR) begin
                new_level  = fse_pkg::LVL_REJECTED;
                new_action = fse_pkg::ACT_REJECT;
            end else if (r_prior.level == fse_pkg::LVL_REJECTED) begin
                new_level  = fse_pkg::LVL_DROPPED;
                new_action = fse_pkg::ACT_DROP;
            end else begin
                new_level  = r_prior.level;
            end
        end
    end

    // Write back the record and hold the verdict.
    always_ff @(posedge i_clk) begin
        if (i_cmd.compute) begin
            r_src_mem[r_src] <= '{ptr: r_next_ptr, level: new_level, count: new_count};
            r_res_action     <= new_action;
            r_res_burst      <= burst;
            r_res_level      <= new_level;
            r_res_count      <= new_count;
        end
    end

    // Record valid bits; a record not yet written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_valid <= '0;
        end else if (i_cmd.compute) begin
            r_src_valid[r_src] <= 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_echo   <= r_echo;
            r_out_action <= r_res_action;
            r_out_burst  <= r_res_burst;
            r_out_level  <= r_res_level;
            r_out_count  <= r_res_count;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.source_echo = r_out_echo;
    assign o_out.action      = r_out_action;
    assign o_out.burst_seen  = r_out_burst;
    assign o_out.level       = r_out_level;
    assign o_out.event_count = r_out_count;

endmodule

// ===== sv/per_source_flood_escalator.sv =====
// Per-source flood escalator.
// The input channel takes one packet event per beat: a source index and its
// arrival time in seconds. The output channel gives one verdict per event:
// the index as received, the action (none, reject, drop), whether the
// window test held, the source's escalation level and its event count.
// The window register is written through i_cfg_we / i_cfg_wdata; the user
// must write it only while idle; the block itself does not enforce this.
// The sequencer walks each event through a record read, a ring address step,
// one ring write plus read on the arrival memory, the window test with record
// write-back and the output register load, then takes the next event.
// Reset clears the per-source valid bits and sets the window register to three
// seconds; the arrival memory is not swept, since a source's fill count
// tells which of its slots were never written. No reset pass is needed.
// When the receiver stalls, the finished verdict waits in the output
// register and the next event is taken, but its verdict waits until the
// previous one has gone.
module per_source_flood_escalator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [fse_pkg::WIN_W-1:0]  i_cfg_wdata,
    fse_in_if.sink                     i_in,
    fse_out_if.source                  o_out
);

    fse_pkg::t_cmd cmd;
    fse_pkg::t_sts sts;

    // Sequencer.
    fse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath with the record and ring memories.
    fse_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .o_out       (o_out)
    );

endmodule

// ===== sv/fse_chk.sv =====
module fse_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [fse_pkg::ACT_W-1:0]   i_action,
    input logic                        i_burst,
    input logic [fse_pkg::LVL_W-1:0]   i_level
);

    // A verdict that is stalled stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("verdict withdrawn while stalled");

    // One event at a time: after a beat is taken the input closes.
    a_in_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input still open after taking an event");

    // An action only follows a burst and names the level reached.
    a_act_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_action != fse_pkg::ACT_NONE) |->
            i_burst && (i_level == i_action))
        else $error("action without burst or level mismatch");

    // Neither action nor level ever takes the unused code.
    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_action <= fse_pkg::ACT_DROP) && (i_level <= fse_pkg::LVL_DROPPED))
        else $error("unused action or level code");

endmodule

bind per_source_flood_escalator fse_chk u_fse_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_action    (o_out.action),
    .i_burst     (o_out.burst_seen),
    .i_level     (o_out.level)
);

// ===== tb/tb_per_source_flood_escalator.sv =====
`timescale 1ns / 1ps

module tb_per_source_flood_escalator;

    // Cycles without any beat on either channel before the run is abandoned.
    localparam int STALL_LIMIT    = 4000;
    // Length of the long receiver hold-off that fills the block up.
    localparam int RX_HOLD_CYCLES = 400;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_EVENTS   = 123;

    // One verdict as it leaves the block.
    typedef struct packed {
        logic [fse_pkg::IDX_W-1:0]   echo;
        logic [fse_pkg::ACT_W-1:0]   action;
        logic                        burst;
        logic [fse_pkg::LVL_W-1:0]   level;
        logic [fse_pkg::COUNT_W-1:0] count;
    } t_verdict;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [fse_pkg::WIN_W-1:0]   i_cfg_wdata;

    fse_in_if  in_ch ();
    fse_out_if out_ch ();

    per_source_flood_escalator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Shadow copy of the per-source history and the window register.
    logic [fse_pkg::TIME_W-1:0]  arrival_hist [fse_pkg::NUM_SOURCES][fse_pkg::RING_EVENTS];
    int unsigned                 hist_slot    [fse_pkg::NUM_SOURCES];
    logic [fse_pkg::LVL_W-1:0]   src_level    [fse_pkg::NUM_SOURCES];
    logic [fse_pkg::COUNT_W-1:0] src_events   [fse_pkg::NUM_SOURCES];
    logic [fse_pkg::WIN_W-1:0]   window_now;

    t_verdict verdict_q [$];
    int       mismatches;
    int       stall_cycles;
    bit       calm_tx;
    bit       calm_rx;
    bit       rx_hold_req;

    // Clock: 2 ns period.
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Work out the verdict for one accepted event and update the shadow state.
    function automatic t_verdict judge_event(input logic [fse_pkg::IDX_W-1:0] idx,
                                             input logic [fse_pkg::TIME_W-1:0] now);
        t_verdict                   v;
        int unsigned                s;
        int unsigned                p;
        int unsigned                nx;
        logic [fse_pkg::TIME_W-1:0] oldest;
        logic signed [63:0]         span;
        s  = int'(idx) % fse_pkg::NUM_SOURCES;
        p  = hist_slot[s] % fse_pkg::RING_EVENTS;
        nx = (p + 1) % fse_pkg::RING_EVENTS;
        if (src_events[s] != '1) begin
            src_events[s] = src_events[s] + 1'b1;
        end
        arrival_hist[s][p] = now;
        oldest = arrival_hist[s][nx];
        span = $signed({32'd0, now}) - $signed({32'd0, oldest});
        v.echo   = idx;
        v.action = fse_pkg::ACT_NONE;
        v.burst  = (span < $signed({56'd0, window_now}));
        if (v.burst) begin
            if (src_level[s] == fse_pkg::LVL_CLEAR) begin
                src_level[s] = fse_pkg::LVL_REJECTED;
                v.action     = fse_pkg::ACT_REJECT;
            end else if (src_level[s] == fse_pkg::LVL_REJECTED) begin
                src_level[s] = fse_pkg::LVL_DROPPED;
                v.action     = fse_pkg::ACT_DROP;
            end
        end
        hist_slot[s] = nx;
        v.level = src_level[s];
        v.count = src_events[s];
        return v;
    endfunction

    // Idle cycles drawn by either side before its next beat.
    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 11));
    endfunction

    // Offer one event and record its verdict once the beat is taken.
    task automatic send_event(input logic [fse_pkg::IDX_W-1:0] idx,
                              input logic [fse_pkg::TIME_W-1:0] t);
        int wait_tx;
        wait_tx = draw_wait(calm_tx);
        if (wait_tx > 0) begin
            in_ch.valid <= 1'b0;
            repeat (wait_tx) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.source_index <= idx;
        in_ch.arrival_sec  <= t;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        verdict_q.push_back(judge_event(idx, t));
    endtask

    // Stop offering and wait until every verdict has come back.
    task automatic await_quiet();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (verdict_q.size() != 0);
    endtask

    // Write the window register while the block is idle.
    task automatic set_window(input logic [fse_pkg::WIN_W-1:0] w);
        await_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        window_now = w;
    endtask

    // Default window: fresh rings compare against time zero, and a source
    // climbs to level two and then stays there on further bursts.
    task automatic test_fresh_ring();
        send_event(8'd0, 32'd0);
        send_event(8'd0, 32'd1);
        send_event(8'd0, 32'd2);
        send_event(8'd1, 32'd3);
        send_event(8'd1, 32'd2);
        send_event(8'd255, 32'hFFFF_FFFF);
        send_event(8'd128, 32'h8000_0000);
        send_event(8'd0, 32'd2);
    endtask

    // Window register at both ends, with the difference right on the limit.
    task automatic test_window_extremes();
        set_window(8'd0);
        send_event(8'd2, 32'd0);
        send_event(8'd2, 32'd0);
        set_window(8'd255);
        send_event(8'd3, 32'd254);
        send_event(8'd3, 32'd255);
        send_event(8'd3, 32'd200);
        send_event(8'd3, 32'd0);
        send_event(8'hAA, 32'h5555_5555);
        send_event(8'h55, 32'hAAAA_AAAA);
    endtask

    // Fill one ring and wrap it so that the oldest time lies after the newest,
    // giving a negative difference.
    task automatic test_ring_wrap();
        set_window(8'd10);
        for (int k = 0; k < fse_pkg::RING_EVENTS - 1; k++) begin
            send_event(8'd7, 32'hFFFF_FF00 + k);
        end
        send_event(8'd7, 32'd5);
        send_event(8'd7, 32'd6);
        send_event(8'd7, 32'hFFFF_FF30);
        send_event(8'd7, 32'hFFFF_FF0C);
        send_event(8'd7, 32'hFFFF_FF0E);
    endtask

    // Receiver holds off for a long stretch while events keep coming.
    task automatic test_backpressure();
        calm_tx     = 1'b1;
        rx_hold_req = 1'b1;
        for (int k = 0; k < 40; k++) begin
            send_event(8'(40 + (k % 3)), 32'(k / 2));
        end
        calm_tx = 1'b0;
        await_quiet();
    endtask

    // Mostly steady streams from two sources per phase, some broken streams
    // with time jumps, and some unrelated noise events.
    task automatic test_random_traffic();
        logic [fse_pkg::IDX_W-1:0]  pool [2];
        logic [fse_pkg::TIME_W-1:0] stream_t [2];
        logic [fse_pkg::WIN_W-1:0]  w;
        int                         step_max;
        int                         r;
        int                         k;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            unique case (ph)
                0:       w = 8'd0;
                1:       w = 8'd255;
                2:       w = 8'd49;
                3:       w = 8'd50;
                default: w = 8'($urandom_range(0, 255));
            endcase
            set_window(w);
            calm_tx  = (ph == 2);
            calm_rx  = (ph == 2);
            step_max = $urandom_range(0, 3);
            for (int j = 0; j < 2; j++) begin
                pool[j]     = 8'($urandom_range(0, 255));
                stream_t[j] = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 5))
                                                          : $urandom();
            end
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                r = $urandom_range(0, 99);
                k = $urandom_range(0, 1);
                if (r < 80) begin
                    stream_t[k] = stream_t[k] + 32'($urandom_range(0, step_max));
                    send_event(pool[k], stream_t[k]);
                end else if (r < 88) begin
                    stream_t[k] = $urandom();
                    send_event(pool[k], stream_t[k]);
                end else begin
                    send_event(8'($urandom_range(0, 255)), $urandom());
                end
            end
        end
        calm_tx = 1'b0;
        calm_rx = 1'b0;
    endtask

    // Receiver: random ready gaps, plus the long hold-off on request.
    initial begin
        int wait_rx;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end
            wait_rx = draw_wait(calm_rx);
            if (wait_rx > 0) begin
                out_ch.ready <= 1'b0;
                repeat (wait_rx) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    // Compare each verdict beat with the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: verdict beat with none outstanding: echo=%0d", $realtime,
                             out_ch.source_echo);
                end
            end else begin
                exp_v = verdict_q.pop_front();
                if (out_ch.source_echo !== exp_v.echo || out_ch.action !== exp_v.action ||
                    out_ch.burst_seen !== exp_v.burst || out_ch.level !== exp_v.level ||
                    out_ch.event_count !== exp_v.count) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: expected echo=%0d action=%0d burst=%0d level=%0d count=%0d",
                                 $realtime, exp_v.echo, exp_v.action, exp_v.burst,
                                 exp_v.level, exp_v.count);
                        $display("%0t: actual   echo=%0d action=%0d burst=%0d level=%0d count=%0d",
                                 $realtime, out_ch.source_echo, out_ch.action,
                                 out_ch.burst_seen, out_ch.level, out_ch.event_count);
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which no beat moves on either channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("per_source_flood_escalator regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Main sequence.
    initial begin
        mismatches   = 0;
        stall_cycles = 0;
        calm_tx      = 1'b0;
        calm_rx      = 1'b0;
        rx_hold_req  = 1'b0;
        window_now   = fse_pkg::WINDOW_RESET;
        for (int s = 0; s < fse_pkg::NUM_SOURCES; s++) begin
            hist_slot[s]  = 0;
            src_level[s]  = fse_pkg::LVL_CLEAR;
            src_events[s] = '0;
            for (int e = 0; e < fse_pkg::RING_EVENTS; e++) begin
                arrival_hist[s][e] = '0;
            end
        end
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_wdata        <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.source_index <= '0;
        in_ch.arrival_sec  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fresh_ring();
        test_window_extremes();
        test_ring_wrap();
        test_backpressure();
        test_random_traffic();

        await_quiet();
        repeat (10) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            mismatches += verdict_q.size();
        end
        if (mismatches == 0) begin
            $display("per_source_flood_escalator regression: pass");
        end else begin
            $display("per_source_flood_escalator regression: fail");
        end
        $finish;
    end

endmodule
